// ===== rtl/core/can_frame_ring_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// CAN frame ring queue assertion macros
// Shared concurrent assertion forms for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_RING_QUEUE_TOP_MACROS_SVH
`define CAN_FRAME_RING_QUEUE_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define CFRQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cfrq invariant violated");

// When the trigger holds, the outcome holds in the next cycle.
`define CFRQ_ASSERT_NEXT(label, clk, rst, trig, outcome) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) \
      else $error("cfrq next-cycle check failed");

`endif

// ===== rtl/core/cfrq_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN frame ring queue package
// Sizes, codes, transfer structs and the byte masking function.
// ----------------------------------------------------------------------------
`default_nettype none

package cfrq_pkg;

   localparam int DEPTH     = 32;
   localparam int NUM_CELLS = DEPTH - 1;
   localparam int CNT_W     = $clog2(DEPTH);
   localparam int LVL_W     = 5;
   localparam int ID_W      = 32;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 64;
   localparam int BYTES     = 8;
   localparam int MAX_LEN   = 8;
   localparam int DROP_W    = 32;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_BAD_LEN  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     push_id;
      logic [LEN_W-1:0]    push_len;
      logic [DATA_W-1:0]   push_data;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     pop_id;
      logic [LEN_W-1:0]    pop_len;
      logic [DATA_W-1:0]   pop_data;
      logic [LVL_W-1:0]    fill_level;
      logic [LVL_W-1:0]    fill_peak;
      logic [DROP_W-1:0]   dropped_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [LEN_W-1:0]    len;
      logic [DATA_W-1:0]   data;
   } frame_type;

   typedef struct packed {
      logic                load;
      logic                shift;
   } cell_ctl_type;

   typedef struct packed {
      logic                push;
      logic                pop;
      logic [CNT_W-1:0]    slot;
   } chain_cmd_type;

   function automatic logic [DATA_W-1:0] mask_bytes(input logic [LEN_W-1:0] len,
                                                    input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] res;
      res = data;
      for (int b = 0; b < BYTES; b++) begin
         if (LEN_W'(b) >= len) begin
            res[b*8 +: 8] = 8'h00;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfrq_cell.sv =====
// ----------------------------------------------------------------------------
// CAN frame ring queue cell
// Holds one frame; loads a new frame or takes its upper neighbor's frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrq_cell (
   input  wire                    clock,
   input  cfrq_pkg::cell_ctl_type ctl,
   input  cfrq_pkg::frame_type    load_frame,
   input  cfrq_pkg::frame_type    shift_frame,
   output cfrq_pkg::frame_type    frame
);
   import cfrq_pkg::*;

   frame_type frame_ff;
   frame_type frame_in;

   always_comb begin
      frame_in = frame_ff;
      if (ctl.load) begin
         frame_in = load_frame;
      end else if (ctl.shift) begin
         frame_in = shift_frame;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame = frame_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cfrq_chain.sv =====
// ----------------------------------------------------------------------------
// CAN frame ring queue cell chain
// Row of frame cells; the oldest frame sits in cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrq_chain (
   input  wire                     clock,
   input  cfrq_pkg::chain_cmd_type cmd,
   input  cfrq_pkg::frame_type     push_frame,
   output cfrq_pkg::frame_type     head_frame
);
   import cfrq_pkg::*;

   frame_type    cell_frame [NUM_CELLS];
   frame_type    cell_src   [NUM_CELLS];
   cell_ctl_type cell_ctl   [NUM_CELLS];

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      if (i == NUM_CELLS - 1) begin : g_last
         assign cell_src[i] = '0;
      end else begin : g_mid
         assign cell_src[i] = cell_frame[i+1];
      end

      assign cell_ctl[i].load  = cmd.push && (cmd.slot == CNT_W'(i));
      assign cell_ctl[i].shift = cmd.pop;

      cfrq_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .load_frame  (push_frame),
         .shift_frame (cell_src[i]),
         .frame       (cell_frame[i])
      );
   end

   assign head_frame = cell_frame[0];

endmodule

`default_nettype wire

// ===== rtl/core/can_frame_ring_queue_top.sv =====
// Results are registered: a result appears in the cycle after its request transfer.
// Throughput: one request per cycle while req_stall is low; each operation is a single step of the
// cell chain (push loads one cell, pop shifts every cell toward the head).
// Reset clears the fill count, watermark, drop counter and result valid.
// Frame cells are not cleared; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// CAN frame ring queue top level
// Frame FIFO with fill tracking, high watermark and a wrapping drop counter.
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_ring_queue_top (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  cfrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output cfrq_pkg::rsp_type rsp_data
);
   import cfrq_pkg::*;
   `include "can_frame_ring_queue_top_macros.svh"

   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;
   logic [CNT_W-1:0]  peak_ff;
   logic [CNT_W-1:0]  peak_in;
   logic [DROP_W-1:0] drop_ff;
   logic [DROP_W-1:0] drop_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic              accept;
   logic              is_full;
   logic              is_empty;
   logic              bad_len;
   logic [CNT_W-1:0]  fill_inc;
   chain_cmd_type     cmd;
   frame_type         push_frame;
   frame_type         head_frame;
   rsp_type           result;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (fill_ff == CNT_W'(NUM_CELLS));
   assign is_empty  = (fill_ff == '0);
   assign bad_len   = (req_data.push_len > LEN_W'(MAX_LEN));
   assign fill_inc  = fill_ff + 1'b1;

   assign push_frame.id   = req_data.push_id;
   assign push_frame.len  = req_data.push_len;
   assign push_frame.data = mask_bytes(req_data.push_len, req_data.push_data);

   always_comb begin
      cmd      = '0;
      cmd.slot = fill_ff;
      fill_in  = fill_ff;
      peak_in  = peak_ff;
      drop_in  = drop_ff;
      result   = '0;
      result.status = ST_OK;
      if (accept) begin
         unique case (req_data.op)
            OP_PUSH: begin
               if (bad_len) begin
                  result.status = ST_BAD_LEN;
               end else if (is_full) begin
                  drop_in       = drop_ff + 1'b1;
                  result.status = ST_DROPPED;
               end else begin
                  cmd.push = 1'b1;
                  fill_in  = fill_inc;
                  if (fill_inc > peak_ff) begin
                     peak_in = fill_inc;
                  end
               end
            end
            OP_POP: begin
               if (is_empty) begin
                  result.status = ST_EMPTY;
               end else begin
                  cmd.pop        = 1'b1;
                  fill_in        = fill_ff - 1'b1;
                  result.pop_id   = head_frame.id;
                  result.pop_len  = head_frame.len;
                  result.pop_data = head_frame.data;
               end
            end
            OP_CLEAR: begin
               fill_in = '0;
               peak_in = '0;
               drop_in = '0;
            end
            default: begin
            end
         endcase
      end
      result.fill_level    = LVL_W'(fill_in);
      result.fill_peak     = LVL_W'(peak_in);
      result.dropped_count = drop_in;
   end

   assign rsp_valid_in = accept || req_stall;
   assign rsp_data_in  = accept ? result : rsp_data_ff;

   cfrq_chain u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .push_frame (push_frame),
      .head_frame (head_frame)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         peak_ff      <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CFRQ_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CNT_W'(NUM_CELLS))
   `CFRQ_ASSERT_ALWAYS(a_peak_covers_fill, clock, reset, peak_ff >= fill_ff)
   `CFRQ_ASSERT_NEXT(a_pop_shrinks, clock, reset,
      accept && (req_data.op == OP_POP) && !is_empty,
      fill_ff == $past(fill_ff) - 1'b1)
   `CFRQ_ASSERT_NEXT(a_drop_counts, clock, reset,
      accept && (req_data.op == OP_PUSH) && !bad_len && is_full,
      (drop_ff == $past(drop_ff) + 1'b1) && (rsp_data_ff.status == ST_DROPPED))

endmodule

`default_nettype wire

// ===== test/frame_queue_checker.sv =====
// ----------------------------------------------------------------------------
// CAN frame ring queue checker
// Watches the request and result channels. For every request transfer it
// works out the expected result from its own copy of the frame queue, and
// compares each result transfer field by field with the oldest expected one.
// ----------------------------------------------------------------------------

module frame_queue_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  cfrq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  cfrq_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                outstanding
);
   import cfrq_pkg::*;

   frame_type         held_frames[$];
   rsp_type           pending_replies[$];
   int                peak_level  = 0;
   logic [DROP_W-1:0] drop_tally  = '0;
   int                error_tally = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   task automatic report_mismatch(input string what);
      if (error_tally < 50) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
      error_tally++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   function automatic rsp_type apply_queue_op(input req_type r);
      rsp_type           res;
      frame_type         f;
      logic [DATA_W-1:0] keep;
      res        = '0;
      res.status = ST_OK;
      case (r.op)
         OP_PUSH: begin
            if (r.push_len > MAX_LEN) begin
               res.status = ST_BAD_LEN;
            end else if (held_frames.size() == DEPTH - 1) begin
               drop_tally = drop_tally + 1'b1;
               res.status = ST_DROPPED;
            end else begin
               keep   = (r.push_len >= MAX_LEN) ? '1 : ((64'd1 << (8 * r.push_len)) - 64'd1);
               f.id   = r.push_id;
               f.len  = r.push_len;
               f.data = r.push_data & keep;
               held_frames.push_back(f);
               if (held_frames.size() > peak_level) begin
                  peak_level = held_frames.size();
               end
            end
         end
         OP_POP: begin
            if (held_frames.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               f            = held_frames.pop_front();
               res.pop_id   = f.id;
               res.pop_len  = f.len;
               res.pop_data = f.data;
            end
         end
         OP_CLEAR: begin
            held_frames.delete();
            peak_level = 0;
            drop_tally = '0;
         end
         default: begin
         end
      endcase
      res.fill_level    = LVL_W'(held_frames.size());
      res.fill_peak     = LVL_W'(peak_level);
      res.dropped_count = drop_tally;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               report_mismatch($sformatf("result %h with no expectation waiting", rsp_data));
            end else begin
               want = pending_replies.pop_front();
               check_field("status", rsp_data.status, want.status);
               check_field("pop_id", rsp_data.pop_id, want.pop_id);
               check_field("pop_len", rsp_data.pop_len, want.pop_len);
               check_field("pop_data", rsp_data.pop_data, want.pop_data);
               check_field("fill_level", rsp_data.fill_level, want.fill_level);
               check_field("fill_peak", rsp_data.fill_peak, want.fill_peak);
               check_field("dropped_count", rsp_data.dropped_count, want.dropped_count);
            end
         end
         if (req_valid && !req_stall) begin
            pending_replies.push_back(apply_queue_op(req_data));
         end
      end
      mismatch_count <= error_tally;
      outstanding    <= pending_replies.size();
   end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// CAN frame ring queue testbench
// Drives a short directed sequence and then runs of random pushes, pops,
// clears and idle operations, with random gaps on both channels and one long
// hold-off on the result side. The checker predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
   import cfrq_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN, CLEAR_RUN} run_kind;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      mismatch_count;
   int      outstanding;

   int      cycle_count     = 0;
   int      items_sent      = 0;
   bit      steady_sender   = 1'b0;
   bit      pressure_due    = 1'b0;
   bit      holding_results = 1'b0;

   can_frame_ring_queue_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   frame_queue_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type frame_item(input op_type op, input logic [ID_W-1:0] id,
                                          input logic [LEN_W-1:0] len,
                                          input logic [DATA_W-1:0] data);
      req_type item;
      item.op        = op;
      item.push_id   = id;
      item.push_len  = len;
      item.push_data = data;
      return item;
   endfunction

   function automatic req_type random_item(input op_type op, input bit legal_len);
      logic [LEN_W-1:0] len;
      int               r;
      r = $urandom_range(0, 9);
      if (!legal_len) begin
         len = LEN_W'($urandom_range(MAX_LEN + 1, 15));
      end else if (r == 0) begin
         len = '0;
      end else if (r == 1) begin
         len = LEN_W'(MAX_LEN);
      end else begin
         len = LEN_W'($urandom_range(0, MAX_LEN));
      end
      return frame_item(op, $urandom, len, {$urandom, $urandom});
   endfunction

   function automatic req_type mixed_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 46) begin
         return random_item(OP_PUSH, $urandom_range(0, 99) < 85);
      end else if (r < 88) begin
         return random_item(OP_POP, 1'b1);
      end else if (r < 95) begin
         return random_item(OP_NOP, $urandom_range(0, 1) == 1);
      end
      return random_item(OP_CLEAR, $urandom_range(0, 1) == 1);
   endfunction

   task automatic offer(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
      gap = (steady_sender || holding_results) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int      run_len;
      int      directed_count;
      run_kind kind;
      bit      first_run;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer(frame_item(OP_POP, '0, '0, '0));
      offer(frame_item(OP_PUSH, '1, 4'd0, '1));
      offer(frame_item(OP_PUSH, '0, 4'd8, '1));
      offer(frame_item(OP_PUSH, 32'h1234_5678, 4'd1, '1));
      offer(frame_item(OP_PUSH, '1, 4'd7, 64'h0123_4567_89ab_cdef));
      offer(frame_item(OP_PUSH, '1, 4'd9, '1));
      offer(frame_item(OP_PUSH, '0, 4'd15, '1));
      offer(frame_item(OP_NOP, '1, 4'd15, '1));
      repeat (5) offer(frame_item(OP_POP, '1, '1, '1));
      offer(random_item(OP_PUSH, 1'b1));
      offer(frame_item(OP_PUSH, $urandom, 4'd8, {$urandom, $urandom}));
      offer(frame_item(OP_PUSH, $urandom, 4'd2, {$urandom, $urandom}));
      offer(frame_item(OP_CLEAR, '0, '0, '0));
      offer(frame_item(OP_POP, '0, '0, '0));
      offer(frame_item(OP_PUSH, $urandom, 4'd5, {$urandom, $urandom}));
      offer(frame_item(OP_POP, '0, '0, '0));
      directed_count = items_sent;

      first_run = 1'b1;
      while (items_sent < directed_count + RANDOM_ITEMS) begin
         if (first_run) begin
            kind    = FILL_RUN;
            run_len = 40;
         end else begin
            kind    = run_kind'($urandom_range(0, 9) / 3);
            run_len = $urandom_range(20, 45);
         end
         first_run     = 1'b0;
         steady_sender = ($urandom_range(0, 3) == 0);
         if (items_sent >= directed_count + 400) begin
            pressure_due = 1'b1;
         end
         case (kind)
            FILL_RUN: begin
               repeat (run_len) offer(random_item(OP_PUSH, $urandom_range(0, 99) < 92));
            end
            DRAIN_RUN: begin
               repeat (run_len) begin
                  offer(random_item(($urandom_range(0, 19) == 0) ? OP_NOP : OP_POP, 1'b1));
               end
            end
            MIXED_RUN: begin
               repeat (run_len) offer(mixed_item());
            end
            default: begin
               offer(random_item(OP_CLEAR, $urandom_range(0, 1) == 1));
               repeat ($urandom_range(1, 6)) offer(mixed_item());
            end
         endcase
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int  stall_len;
      bit  pressure_done;
      pressure_done = 1'b0;
      rsp_stall     = 1'b0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (pressure_due && !pressure_done) begin
            pressure_done   = 1'b1;
            holding_results = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding_results = 1'b0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            stall_len = idle_length();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(40, 150)) @(posedge clock);
            end else begin
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end
         end
      end
   end

endmodule
